### rtl/gpt_pkg.sv
// Shared types and character constants for the glob pattern tokenizer.
// No dependencies; imported by every module of the block.
package gpt_pkg;

  localparam logic [7:0] CHR_BACKSLASH = 8'h5C;
  localparam logic [7:0] CHR_OPEN      = 8'h5B;
  localparam logic [7:0] CHR_CLOSE     = 8'h5D;
  localparam logic [7:0] CHR_STAR      = 8'h2A;
  localparam logic [7:0] CHR_QUEST     = 8'h3F;

  typedef enum logic [2:0] {
    KIND_LIT    = 3'd0,
    KIND_MEMBER = 3'd1,
    KIND_ONE    = 3'd2,
    KIND_RUN    = 3'd3,
    KIND_END    = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK           = 2'd0,
    ST_STRAY_CLOSE  = 2'd1,
    ST_OPEN_IN_CLS  = 2'd2,
    ST_UNTERMINATED = 2'd3
  } status_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] chr;
    logic       starts;
    status_t    status;
    logic       last;
  } token_t;

  // One queue entry: all tokens caused by one input word.
  typedef struct packed {
    token_t tok0;
    token_t tok1;
    logic   two;
  } entry_t;

endpackage

### rtl/glob_pattern_tokenizer.sv
// Glob pattern tokenizer top level: front end, token queue, back end.
// A word's first token appears on out_* at the earliest after the queue write and then
// the back-end load. Throughput: one input word per cycle while the queue is not full;
// the output side moves one token per cycle while out_tready is high, so a word that
// makes two tokens holds the output for both tokens. Reset (rst_n low, synchronous)
// returns to normal mode, no open part, and empties the queue and the output stage.
module glob_pattern_tokenizer #(
  parameter int FIFO_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] pattern_byte
  input  logic        in_tlast,   // end_of_pattern
  // Token stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [7:0] token_byte, [8] starts_part, [10:9] status, rest 0
  output logic [2:0]  out_tuser,  // [2:0] token_kind
  output logic        out_tlast   // last_of_item
);
  import gpt_pkg::*;

  logic   in_acc;
  logic   push, full;
  entry_t f_entry, q_entry;
  logic   q_valid, q_pop;
  token_t tok;

  // Front end never stalls on its own; hold input only while the queue is full.
  assign in_tready = !full;
  assign in_acc    = in_tvalid && in_tready;

  gpt_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .accept         (in_acc),
    .pattern_byte   (in_tdata),
    .end_of_pattern (in_tlast),
    .push           (push),
    .entry          (f_entry)
  );

  gpt_queue #(
    .DEPTH (FIFO_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .wr_data  (f_entry),
    .full     (full),
    .pop      (q_pop),
    .rd_valid (q_valid),
    .rd_data  (q_entry)
  );

  gpt_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_data    (q_entry),
    .q_pop     (q_pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_tok   (tok)
  );

  // Pack the token word.
  assign out_tdata = {5'b00000, tok.status, tok.starts, tok.chr};
  assign out_tuser = tok.kind;
  assign out_tlast = tok.last;

  // End token never opens a part and always closes its word.
  a_end_token: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == KIND_END |-> !out_tdata[8] && out_tlast)
    else $error("end token with starts_part set or not last");

  // Wildcards always open a part and carry no character.
  a_wildcard: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == KIND_ONE || out_tuser == KIND_RUN)
      |-> out_tdata[8] && out_tdata[7:0] == 8'h00)
    else $error("wildcard token malformed");

  // Unterminated-class status appears only on an end token.
  a_unterm: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[10:9] == ST_UNTERMINATED |-> out_tuser == KIND_END)
    else $error("unterminated status on a non-end token");

endmodule

### rtl/gpt_front.sv
// Front end: mode and last-part tracking, classifies each input word into tokens.
// Depends on gpt_pkg.
module gpt_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            accept,
  input  logic [7:0]      pattern_byte,
  input  logic            end_of_pattern,
  output logic            push,
  output gpt_pkg::entry_t entry
);
  import gpt_pkg::*;

  typedef enum logic [1:0] {
    M_NORMAL    = 2'd0,
    M_ESC       = 2'd1,
    M_CLASS     = 2'd2,
    M_CLASS_ESC = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    P_NONE  = 3'd0,
    P_LIT   = 3'd1,
    P_CLASS = 3'd2,
    P_ONE   = 3'd3,
    P_RUN   = 3'd4
  } part_t;

  mode_t mode_r, mode_nxt;
  part_t part_r, part_nxt;
  logic  [1:0] n_tok;

  function automatic token_t mk(kind_t k, logic [7:0] c, logic s, status_t st);
    token_t t;
    t.kind   = k;
    t.chr    = c;
    t.starts = s;
    t.status = st;
    t.last   = 1'b0;
    return t;
  endfunction

  always_comb begin
    mode_nxt   = mode_r;
    part_nxt   = part_r;
    n_tok      = 2'd0;
    entry.tok0 = mk(KIND_END, 8'h00, 1'b0, ST_OK);
    entry.tok1 = mk(KIND_END, 8'h00, 1'b0, ST_OK);
    if (end_of_pattern) begin
      mode_nxt = M_NORMAL;
      part_nxt = P_NONE;
      unique case (mode_r) inside
        M_ESC: begin
          entry.tok0 = mk(KIND_LIT, CHR_BACKSLASH, part_r != P_LIT, ST_OK);
          entry.tok1 = mk(KIND_END, 8'h00, 1'b0, ST_OK);
          n_tok      = 2'd2;
        end
        M_CLASS, M_CLASS_ESC: begin
          entry.tok0 = mk(KIND_END, 8'h00, 1'b0, ST_UNTERMINATED);
          n_tok      = 2'd1;
        end
        default: begin
          entry.tok0 = mk(KIND_END, 8'h00, 1'b0, ST_OK);
          n_tok      = 2'd1;
        end
      endcase
    end else begin
      unique case (mode_r)
        M_NORMAL: begin
          if (pattern_byte == CHR_BACKSLASH) begin
            mode_nxt = M_ESC;
          end else if (pattern_byte == CHR_OPEN) begin
            mode_nxt = M_CLASS;
          end else if (pattern_byte == CHR_CLOSE) begin
            entry.tok0 = mk(KIND_LIT, pattern_byte, part_r != P_LIT, ST_STRAY_CLOSE);
            part_nxt   = P_LIT;
            n_tok      = 2'd1;
          end else if (pattern_byte == CHR_STAR) begin
            // Drop a run wildcard that follows another.
            if (part_r != P_RUN) begin
              entry.tok0 = mk(KIND_RUN, 8'h00, 1'b1, ST_OK);
              part_nxt   = P_RUN;
              n_tok      = 2'd1;
            end
          end else if (pattern_byte == CHR_QUEST) begin
            entry.tok0 = mk(KIND_ONE, 8'h00, 1'b1, ST_OK);
            part_nxt   = P_ONE;
            n_tok      = 2'd1;
          end else begin
            entry.tok0 = mk(KIND_LIT, pattern_byte, part_r != P_LIT, ST_OK);
            part_nxt   = P_LIT;
            n_tok      = 2'd1;
          end
        end
        M_ESC: begin
          mode_nxt = M_NORMAL;
          part_nxt = P_LIT;
          if (pattern_byte == CHR_BACKSLASH || pattern_byte == CHR_OPEN ||
              pattern_byte == CHR_CLOSE || pattern_byte == CHR_STAR ||
              pattern_byte == CHR_QUEST) begin
            entry.tok0 = mk(KIND_LIT, pattern_byte, part_r != P_LIT, ST_OK);
            n_tok      = 2'd1;
          end else begin
            entry.tok0 = mk(KIND_LIT, CHR_BACKSLASH, part_r != P_LIT, ST_OK);
            entry.tok1 = mk(KIND_LIT, pattern_byte, 1'b0, ST_OK);
            n_tok      = 2'd2;
          end
        end
        M_CLASS: begin
          if (pattern_byte == CHR_BACKSLASH) begin
            mode_nxt = M_CLASS_ESC;
          end else if (pattern_byte == CHR_CLOSE) begin
            mode_nxt = M_NORMAL;
            part_nxt = P_NONE;
          end else begin
            entry.tok0 = mk(KIND_MEMBER, pattern_byte, part_r != P_CLASS,
                            (pattern_byte == CHR_OPEN) ? ST_OPEN_IN_CLS : ST_OK);
            part_nxt   = P_CLASS;
            n_tok      = 2'd1;
          end
        end
        default: begin
          mode_nxt = M_CLASS;
          part_nxt = P_CLASS;
          if (pattern_byte == CHR_BACKSLASH || pattern_byte == CHR_OPEN ||
              pattern_byte == CHR_CLOSE) begin
            entry.tok0 = mk(KIND_MEMBER, pattern_byte, part_r != P_CLASS, ST_OK);
            n_tok      = 2'd1;
          end else begin
            entry.tok0 = mk(KIND_MEMBER, CHR_BACKSLASH, part_r != P_CLASS, ST_OK);
            entry.tok1 = mk(KIND_MEMBER, pattern_byte, 1'b0, ST_OK);
            n_tok      = 2'd2;
          end
        end
      endcase
    end
    entry.two       = (n_tok == 2'd2);
    entry.tok0.last = (n_tok == 2'd1);
    entry.tok1.last = 1'b1;
    push            = accept && (n_tok != 2'd0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_NORMAL;
      part_r <= P_NONE;
    end else if (accept) begin
      mode_r <= mode_nxt;
      part_r <= part_nxt;
    end
  end

endmodule

### rtl/gpt_queue.sv
// Short queue of token entries between front end and back end.
// Depends on gpt_pkg.
module gpt_queue #(
  parameter int DEPTH = 4
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  gpt_pkg::entry_t wr_data,
  output logic            full,
  input  logic            pop,
  output logic            rd_valid,
  output gpt_pkg::entry_t rd_data
);
  import gpt_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  entry_t             mem [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]   count_r;
  logic               do_pop;

  assign full     = (count_r == CNT_W'(DEPTH));
  assign rd_valid = (count_r != '0);
  assign rd_data  = mem[rd_ptr_r];
  assign do_pop   = pop && rd_valid;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (!push && do_pop) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

### rtl/gpt_back.sv
// Back end: holds one queue entry and streams its one or two tokens out.
// Depends on gpt_pkg.
module gpt_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_valid,
  input  gpt_pkg::entry_t q_data,
  output logic            q_pop,
  output logic            out_valid,
  input  logic            out_ready,
  output gpt_pkg::token_t out_tok
);
  import gpt_pkg::*;

  entry_t hold_r;
  logic   valid_r;
  logic   idx_r;
  logic   fire, done;

  assign fire      = valid_r && out_ready;
  assign done      = fire && (idx_r || !hold_r.two);
  assign q_pop     = !valid_r || done;
  assign out_valid = valid_r;
  assign out_tok   = idx_r ? hold_r.tok1 : hold_r.tok0;

  always_ff @(posedge clk) begin
    if (q_pop && q_valid) begin
      hold_r <= q_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= 1'b0;
    end else if (q_pop) begin
      valid_r <= q_valid;
      idx_r   <= 1'b0;
    end else if (fire) begin
      // Advance to the second token of the entry.
      idx_r <= 1'b1;
    end
  end

endmodule
